// ===== hw/rtl/accel_calibration_sequencer_assert.svh =====
// assertion macros for the accel calibration sequencer rtl
// expects clk and rst_n in the scope of every module that uses them
`ifndef ACCEL_CALIBRATION_SEQUENCER_ASSERT_SVH
`define ACCEL_CALIBRATION_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define ACS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock outside reset
`define ACS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ACS_ASSERT(lbl, prop, msg)
`define ACS_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/acs_pkg.sv =====
// shared types, constants and helper functions of the accel calibration sequencer
// no dependencies
package acs_pkg;

  // field widths
  localparam int SAMPLE_W   = 10;
  localparam int OFF_W      = 13;
  localparam int STEP_W     = 8;
  localparam int THR_W      = 4;
  localparam int ONEG_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // phase counter boundaries
  localparam logic [STEP_W-1:0] PH_WAIT = 8'd32;
  localparam logic [STEP_W-1:0] PH_FLAT = 8'd128;
  localparam logic [STEP_W-1:0] PH_CAL  = 8'd160;

  // register reset values
  localparam logic [THR_W-1:0]  THR_RESET  = 4'd2;
  localparam logic [ONEG_W-1:0] ONEG_RESET = 9'd64;

  // offset saturation limits on the widened update
  localparam logic signed [14:0] OFF_LO = -15'sd4096;
  localparam logic signed [14:0] OFF_HI = 15'sd4095;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_THRESH  = 3'd3,
    REG_ONE_G   = 3'd4
  } cfg_reg_t;

  // one input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
    logic                       buttons_held;
  } sample_t;

  // one result word
  typedef struct packed {
    logic [STEP_W-1:0]          step_count;
    logic signed [SAMPLE_W-1:0] mean_x;
    logic signed [SAMPLE_W-1:0] mean_y;
    logic signed [SAMPLE_W-1:0] mean_z;
    logic signed [OFF_W-1:0]    offset_out_x;
    logic signed [OFF_W-1:0]    offset_out_y;
    logic signed [OFF_W-1:0]    offset_out_z;
    logic                       offset_load;
    logic                       save_request;
  } result_t;

  // magnitude of a mean or of a difference against a mean (never the most negative code)
  function automatic logic [SAMPLE_W-1:0] abs11(input logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W:0] n;
    begin
      n = -v;
      return v[SAMPLE_W] ? n[SAMPLE_W-1:0] : v[SAMPLE_W-1:0];
    end
  endfunction

  // clamp a widened offset update into the offset range
  function automatic logic signed [OFF_W-1:0] sat15(input logic signed [14:0] v);
    logic signed [14:0] c;
    begin
      if (v < OFF_LO) begin
        c = OFF_LO;
      end else if (v > OFF_HI) begin
        c = OFF_HI;
      end else begin
        c = v;
      end
      return c[OFF_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/acs_channels.sv =====
// valid/ready channel interfaces for sample words in and result words out
// depends on acs_pkg
interface acs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [acs_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [acs_pkg::SAMPLE_W-1:0] sample_y;
  logic signed [acs_pkg::SAMPLE_W-1:0] sample_z;
  logic                                buttons_held;

  modport source (output valid, sample_x, sample_y, sample_z, buttons_held, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, buttons_held, output ready);
endinterface

interface acs_out_if;
  logic                                valid;
  logic                                ready;
  logic [acs_pkg::STEP_W-1:0]          step_count;
  logic signed [acs_pkg::SAMPLE_W-1:0] mean_x;
  logic signed [acs_pkg::SAMPLE_W-1:0] mean_y;
  logic signed [acs_pkg::SAMPLE_W-1:0] mean_z;
  logic signed [acs_pkg::OFF_W-1:0]    offset_out_x;
  logic signed [acs_pkg::OFF_W-1:0]    offset_out_y;
  logic signed [acs_pkg::OFF_W-1:0]    offset_out_z;
  logic                                offset_load;
  logic                                save_request;

  modport source (output valid, step_count, mean_x, mean_y, mean_z, offset_out_x,
                  offset_out_y, offset_out_z, offset_load, save_request, input ready);
  modport sink   (input valid, step_count, mean_x, mean_y, mean_z, offset_out_x,
                  offset_out_y, offset_out_z, offset_load, save_request, output ready);
endinterface

// ===== hw/rtl/accel_calibration_sequencer.sv =====
// top level of the accel calibration sequencer
// depends on acs_pkg, acs_channels, acs_core and acs_out_queue
//
// channel  dir  handshake      word
// in_ch    in   valid/ready    sample_x/y/z, buttons_held
// out_ch   out  valid/ready    step_count, mean_x/y/z, offset_out_x/y/z, offset_load,
//                              save_request
// cfg_*    in   write enable   cfg_index, cfg_wdata
//
// one word accepted per cycle while the queue has room; its result is registered in the queue
// throughput is one word per clock while the queue has room, as the state registers update per word
// the two-entry result queue keeps in_ch.ready high while one result waits
// reset is synchronous and active low, with no clearing pass

module accel_calibration_sequencer #(
  parameter int AVG_SHIFT = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [acs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  acs_in_if.sink                         in_ch,
  acs_out_if.source                      out_ch
);

  acs_pkg::sample_t in_word;
  acs_pkg::result_t res;
  acs_pkg::result_t head;
  logic             q_full;
  logic             q_not_empty;
  logic             in_push;
  logic             out_pop;

  assign in_word.sample_x     = in_ch.sample_x;
  assign in_word.sample_y     = in_ch.sample_y;
  assign in_word.sample_z     = in_ch.sample_z;
  assign in_word.buttons_held = in_ch.buttons_held;

  // accept while the queue has room
  assign in_ch.ready = !q_full;
  assign in_push     = in_ch.valid && !q_full;
  assign out_pop     = q_not_empty && out_ch.ready;

  acs_core #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_word   (in_word),
    .res       (res)
  );

  acs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_word (res),
    .pop       (out_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_word (head)
  );

  // result channel driven from the queue head
  assign out_ch.valid        = q_not_empty;
  assign out_ch.step_count   = head.step_count;
  assign out_ch.mean_x       = head.mean_x;
  assign out_ch.mean_y       = head.mean_y;
  assign out_ch.mean_z       = head.mean_z;
  assign out_ch.offset_out_x = head.offset_out_x;
  assign out_ch.offset_out_y = head.offset_out_y;
  assign out_ch.offset_out_z = head.offset_out_z;
  assign out_ch.offset_load  = head.offset_load;
  assign out_ch.save_request = head.save_request;

endmodule

// ===== hw/rtl/acs_core.sv =====
// sequencer state: sample accumulators, means, phase counter, offsets, config registers
// depends on acs_pkg and accel_calibration_sequencer_assert.svh
`include "accel_calibration_sequencer_assert.svh"

module acs_core #(
  parameter int AVG_SHIFT = 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [acs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [acs_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_push,
  input  acs_pkg::sample_t                       in_word,
  output acs_pkg::result_t                       res
);

  localparam int SW    = acs_pkg::SAMPLE_W;
  localparam int OW    = acs_pkg::OFF_W;
  localparam int SUM_W = SW + AVG_SHIFT;

  logic signed [SUM_W-1:0] sum_r       [3];
  logic signed [SUM_W-1:0] sum_nxt     [3];
  logic signed [SW-1:0]    last_mean_r [3];
  logic signed [SW-1:0]    last_mean_nxt [3];
  logic signed [OW-1:0]    offset_r    [3];
  logic signed [OW-1:0]    offset_nxt  [3];
  logic [acs_pkg::STEP_W-1:0] phase_r;
  logic [acs_pkg::STEP_W-1:0] phase_nxt;
  logic [acs_pkg::THR_W-1:0]  thresh_r;
  logic [acs_pkg::ONEG_W-1:0] one_g_r;

  logic signed [SW-1:0]    smp      [3];
  logic signed [SUM_W-1:0] sum_add  [3];
  logic signed [SW-1:0]    mean     [3];
  logic signed [SW:0]      dlt      [3];
  logic signed [SW:0]      err      [3];
  logic signed [OW-1:0]    off_cal  [3];
  logic [SW+1:0]           diff;
  logic [SW+1:0]           err_sum;
  logic [acs_pkg::STEP_W-1:0] phase_inc;
  logic                    tick;
  logic                    still;
  logic                    load;
  logic                    save;

  // accumulate, average and step the phase sequence
  always_comb begin
    smp[0] = in_word.sample_x;
    smp[1] = in_word.sample_y;
    smp[2] = in_word.sample_z;
    for (int i = 0; i < 3; i++) begin
      sum_add[i] = sum_r[i] + {{AVG_SHIFT{smp[i][SW-1]}}, smp[i]};
      // arithmetic shift right keeps the top bits of the sum
      mean[i]    = sum_add[i][SUM_W-1 -: SW];
      dlt[i]     = {mean[i][SW-1], mean[i]} - {last_mean_r[i][SW-1], last_mean_r[i]};
    end
    diff = {2'b00, acs_pkg::abs11(dlt[0])} + {2'b00, acs_pkg::abs11(dlt[1])}
         + {2'b00, acs_pkg::abs11(dlt[2])};
    still = diff <= {{(SW+2-acs_pkg::THR_W){1'b0}}, thresh_r};

    // error against level with one g on z
    err[0] = {mean[0][SW-1], mean[0]};
    err[1] = {mean[1][SW-1], mean[1]};
    err[2] = {mean[2][SW-1], mean[2]} - {{(SW+1-acs_pkg::ONEG_W){1'b0}}, one_g_r};
    err_sum = {1'b0, acs_pkg::abs11(err[0])} + {1'b0, acs_pkg::abs11(err[1])}
            + {1'b0, acs_pkg::abs11(err[2])};
    for (int i = 0; i < 3; i++) begin
      off_cal[i] = acs_pkg::sat15({{2{offset_r[i][OW-1]}}, offset_r[i]}
                                  - {{3{err[i][SW]}}, err[i], 1'b0});
    end

    phase_inc = phase_r + 8'd1;
    tick      = phase_inc[AVG_SHIFT-1:0] == '0;

    phase_nxt = phase_inc;
    load      = 1'b0;
    save      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i]       = sum_add[i];
      last_mean_nxt[i] = last_mean_r[i];
      offset_nxt[i]    = offset_r[i];
    end

    if (tick) begin
      for (int i = 0; i < 3; i++) begin
        sum_nxt[i]       = '0;
        last_mean_nxt[i] = mean[i];
      end
      priority if (phase_inc <= acs_pkg::PH_WAIT) begin
        if (!in_word.buttons_held) begin
          phase_nxt = '0;
        end
      end else if (phase_inc <= acs_pkg::PH_FLAT) begin
        // keep flat; clear the offset at the end of the flat phase
        if (!still) begin
          phase_nxt = acs_pkg::PH_WAIT;
        end else if (phase_inc == acs_pkg::PH_FLAT) begin
          for (int i = 0; i < 3; i++) begin
            offset_nxt[i] = '0;
          end
          load = 1'b1;
        end
      end else begin
        // calibrate: save when close to one g, otherwise correct and retry
        if (!still) begin
          phase_nxt = acs_pkg::PH_FLAT;
        end else if (phase_inc == acs_pkg::PH_CAL) begin
          if (err_sum <= {{(SW+2-acs_pkg::THR_W){1'b0}}, thresh_r}) begin
            save      = 1'b1;
            phase_nxt = '0;
          end else begin
            for (int i = 0; i < 3; i++) begin
              offset_nxt[i] = off_cal[i];
            end
            load      = 1'b1;
            phase_nxt = acs_pkg::PH_FLAT;
          end
        end
      end
    end
  end

  // result word of the current item
  always_comb begin
    res.step_count   = phase_nxt;
    res.mean_x       = last_mean_nxt[0];
    res.mean_y       = last_mean_nxt[1];
    res.mean_z       = last_mean_nxt[2];
    res.offset_out_x = offset_nxt[0];
    res.offset_out_y = offset_nxt[1];
    res.offset_out_z = offset_nxt[2];
    res.offset_load  = load;
    res.save_request = save;
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      thresh_r <= acs_pkg::THR_RESET;
      one_g_r  <= acs_pkg::ONEG_RESET;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]       <= '0;
        last_mean_r[i] <= '0;
        offset_r[i]    <= '0;
      end
    end else if (cfg_we) begin
      unique case (acs_pkg::cfg_reg_t'(cfg_index))
        acs_pkg::REG_START_X: offset_r[0] <= cfg_wdata;
        acs_pkg::REG_START_Y: offset_r[1] <= cfg_wdata;
        acs_pkg::REG_START_Z: offset_r[2] <= cfg_wdata;
        acs_pkg::REG_THRESH:  thresh_r    <= cfg_wdata[acs_pkg::THR_W-1:0];
        acs_pkg::REG_ONE_G:   one_g_r     <= cfg_wdata[acs_pkg::ONEG_W-1:0];
        default: begin
        end
      endcase
    end else if (in_push) begin
      phase_r <= phase_nxt;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]       <= sum_nxt[i];
        last_mean_r[i] <= last_mean_nxt[i];
        offset_r[i]    <= offset_nxt[i];
      end
    end
  end

  // phase never runs past the calibration point
  `ACS_ASSERT(a_phase_range, phase_r <= acs_pkg::PH_CAL, "phase counter beyond calibration point")
  // load and save only on an averaging boundary and never together
  `ACS_NEVER(a_load_save, in_push && res.offset_load && res.save_request, "load and save together")
  `ACS_ASSERT(a_flag_tick, (in_push && (res.offset_load || res.save_request)) |-> tick, "flag off boundary")
  // the x and z accumulators are cleared after each boundary item
  `ACS_ASSERT(a_sum_clear, (in_push && tick && !cfg_we) |=> (sum_r[0] == '0 && sum_r[2] == '0), "sum not cleared")

endmodule

// ===== hw/rtl/acs_out_queue.sv =====
// two-entry result queue between the sequencer logic and the result channel
// depends on acs_pkg and accel_calibration_sequencer_assert.svh
`include "accel_calibration_sequencer_assert.svh"

module acs_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  acs_pkg::result_t push_word,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output acs_pkg::result_t head_word
);

  acs_pkg::result_t ent_r [2];
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             rd_ptr_r;
  logic             wr_ptr_r;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head_word = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_word;
    end
  end

  `ACS_NEVER(a_count_max, count_r == 2'd3, "queue count out of range")
  `ACS_ASSERT(a_ptr_track, (count_r == 2'd0 || count_r == 2'd2) |-> (rd_ptr_r == wr_ptr_r), "pointers disagree with count")

endmodule

// ===== dv/tb.sv =====
// self-checking testbench of accel_calibration_sequencer: random and directed sample words,
// expected status words from an in-bench model of the calibration sequence
// depends on acs_pkg, acs_channels and accel_calibration_sequencer from the rtl
`timescale 1ns / 1ps

module tb;

  localparam int AVG_SHIFT       = 3;
  localparam int SAMPLE_MAX      = (1 << (acs_pkg::SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN      = -(1 << (acs_pkg::SAMPLE_W - 1));
  localparam int WORDS_PER_PHASE = 150;
  localparam int TIMEOUT_CYCLES  = 200000;
  localparam int MAX_REPORTS     = 10;
  localparam logic [acs_pkg::STEP_W-1:0] AVG_MASK = acs_pkg::STEP_W'((1 << AVG_SHIFT) - 1);

  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [acs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [acs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  acs_in_if  in_bus ();
  acs_out_if out_bus ();

  accel_calibration_sequencer #(
    .AVG_SHIFT(AVG_SHIFT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  // clock
  always #10 clk = ~clk;

  // model state of the sequence
  int                         model_sum[3];
  int                         model_mean[3];
  int                         model_offset[3];
  logic [acs_pkg::STEP_W-1:0] model_phase;
  int                         model_thr;
  int                         model_one_g;

  // stimulus and expectation stores
  acs_pkg::sample_t pending_samples[$];
  acs_pkg::result_t expected_status[$];
  acs_pkg::sample_t driven_sample;
  acs_pkg::result_t seen_status;
  idle_mode_t gap_mode = IDLE_RX_HEAVY;
  int         words_queued   = 0;
  int         words_accepted = 0;
  int         results_seen   = 0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // next status word of the sequencer for one accepted sample word
  function automatic acs_pkg::result_t predict_calibration_step(input acs_pkg::sample_t w);
    acs_pkg::result_t r;
    int      smp[3];
    int      err[3];
    int      change;
    int      nxt;
    bit      is_still;
    bit      load;
    bit      save;
    load   = 1'b0;
    save   = 1'b0;
    smp[0] = w.sample_x;
    smp[1] = w.sample_y;
    smp[2] = w.sample_z;
    for (int i = 0; i < 3; i++) model_sum[i] += smp[i];
    model_phase = model_phase + 1'b1;

    // a new mean every eight words
    if ((model_phase & AVG_MASK) == '0) begin
      change = 0;
      for (int i = 0; i < 3; i++) begin
        nxt           = model_sum[i] >>> AVG_SHIFT;
        change       += abs_int(nxt - model_mean[i]);
        model_mean[i] = nxt;
        model_sum[i]  = 0;
      end
      is_still = (change <= model_thr);

      if (model_phase <= acs_pkg::PH_WAIT) begin
        if (!w.buttons_held) model_phase = '0;
      end else if (model_phase <= acs_pkg::PH_FLAT) begin
        if (!is_still) begin
          model_phase = acs_pkg::PH_WAIT;
        end else if (model_phase == acs_pkg::PH_FLAT) begin
          for (int i = 0; i < 3; i++) model_offset[i] = 0;
          load = 1'b1;
        end
      end else if (!is_still) begin
        model_phase = acs_pkg::PH_FLAT;
      end else if (model_phase == acs_pkg::PH_CAL) begin
        err[0] = model_mean[0];
        err[1] = model_mean[1];
        err[2] = model_mean[2] - model_one_g;
        if (abs_int(err[0]) + abs_int(err[1]) + abs_int(err[2]) <= model_thr) begin
          save        = 1'b1;
          model_phase = '0;
        end else begin
          // move by twice the error, saturated
          for (int i = 0; i < 3; i++) begin
            nxt = model_offset[i] - 2 * err[i];
            if (nxt < int'(acs_pkg::OFF_LO)) nxt = int'(acs_pkg::OFF_LO);
            if (nxt > int'(acs_pkg::OFF_HI)) nxt = int'(acs_pkg::OFF_HI);
            model_offset[i] = nxt;
          end
          load        = 1'b1;
          model_phase = acs_pkg::PH_FLAT;
        end
      end
    end

    r.step_count   = model_phase;
    r.mean_x       = model_mean[0][acs_pkg::SAMPLE_W-1:0];
    r.mean_y       = model_mean[1][acs_pkg::SAMPLE_W-1:0];
    r.mean_z       = model_mean[2][acs_pkg::SAMPLE_W-1:0];
    r.offset_out_x = model_offset[0][acs_pkg::OFF_W-1:0];
    r.offset_out_y = model_offset[1][acs_pkg::OFF_W-1:0];
    r.offset_out_z = model_offset[2][acs_pkg::OFF_W-1:0];
    r.offset_load  = load;
    r.save_request = save;
    return r;
  endfunction

  // register write as the block sees it
  function automatic void apply_register(input logic [acs_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [acs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      acs_pkg::REG_START_X, acs_pkg::REG_START_Y, acs_pkg::REG_START_Z: begin
        model_offset[idx] = int'(signed'(data));
      end
      acs_pkg::REG_THRESH: model_thr   = int'(data[acs_pkg::THR_W-1:0]);
      acs_pkg::REG_ONE_G:  model_one_g = int'(data[acs_pkg::ONEG_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic int idle_pct(input bit sender_side);
    case (gap_mode)
      IDLE_RX_HEAVY: return sender_side ? 17 : 76;
      IDLE_TX_HEAVY: return sender_side ? 76 : 17;
      default:       return 0;
    endcase
  endfunction

  function automatic string status_str(input acs_pkg::result_t r);
    return $sformatf("step=%0d mean=(%0d,%0d,%0d) offset=(%0d,%0d,%0d) load=%0b save=%0b",
                     r.step_count, r.mean_x, r.mean_y, r.mean_z, r.offset_out_x,
                     r.offset_out_y, r.offset_out_z, r.offset_load, r.save_request);
  endfunction

  function automatic int rnd_sample();
    return int'($urandom_range(SAMPLE_MAX - SAMPLE_MIN)) + SAMPLE_MIN;
  endfunction

  function automatic int rnd_offset();
    return int'($urandom_range(int'(acs_pkg::OFF_HI) - int'(acs_pkg::OFF_LO)))
           + int'(acs_pkg::OFF_LO);
  endfunction

  function automatic int fit_sample(input int v);
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_status(input acs_pkg::result_t want, input acs_pkg::result_t got);
    string bad;
    bad = "";
    if (got.step_count   !== want.step_count)   bad = {bad, " step_count"};
    if (got.mean_x       !== want.mean_x)       bad = {bad, " mean_x"};
    if (got.mean_y       !== want.mean_y)       bad = {bad, " mean_y"};
    if (got.mean_z       !== want.mean_z)       bad = {bad, " mean_z"};
    if (got.offset_out_x !== want.offset_out_x) bad = {bad, " offset_out_x"};
    if (got.offset_out_y !== want.offset_out_y) bad = {bad, " offset_out_y"};
    if (got.offset_out_z !== want.offset_out_z) bad = {bad, " offset_out_z"};
    if (got.offset_load  !== want.offset_load)  bad = {bad, " offset_load"};
    if (got.save_request !== want.save_request) bad = {bad, " save_request"};
    if (bad != "") begin
      note_failure($sformatf("status word %0d differs in%s\n  expected %s\n  actual   %s",
                             results_seen, bad, status_str(want), status_str(got)));
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_status.push_back(predict_calibration_step(driven_sample));
        words_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          driven_sample        = pending_samples.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.sample_x     <= driven_sample.sample_x;
          in_bus.sample_y     <= driven_sample.sample_y;
          in_bus.sample_z     <= driven_sample.sample_z;
          in_bus.buttons_held <= driven_sample.buttons_held;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // status monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen_status.step_count   = out_bus.step_count;
        seen_status.mean_x       = out_bus.mean_x;
        seen_status.mean_y       = out_bus.mean_y;
        seen_status.mean_z       = out_bus.mean_z;
        seen_status.offset_out_x = out_bus.offset_out_x;
        seen_status.offset_out_y = out_bus.offset_out_y;
        seen_status.offset_out_z = out_bus.offset_out_z;
        seen_status.offset_load  = out_bus.offset_load;
        seen_status.save_request = out_bus.save_request;
        if (expected_status.size() == 0) begin
          note_failure($sformatf("status word %0d arrived with nothing expected: %s",
                                 results_seen, status_str(seen_status)));
        end else begin
          check_status(expected_status.pop_front(), seen_status);
        end
        results_seen++;
      end
      out_bus.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d status words outstanding",
               cycle_count, expected_status.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_word(input int x, input int y, input int z, input bit held);
    acs_pkg::sample_t w;
    w.sample_x     = x[acs_pkg::SAMPLE_W-1:0];
    w.sample_y     = y[acs_pkg::SAMPLE_W-1:0];
    w.sample_z     = z[acs_pkg::SAMPLE_W-1:0];
    w.buttons_held = held;
    pending_samples.push_back(w);
    words_queued++;
  endtask

  // register write, called right after a rising edge; the caller drops cfg_we
  task automatic cfg_write(input logic [acs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acs_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic load_settings(input int ox, input int oy, input int oz,
                               input int thr, input int one_g);
    cfg_write(acs_pkg::REG_START_X, ox[acs_pkg::CFG_DATA_W-1:0]);
    cfg_write(acs_pkg::REG_START_Y, oy[acs_pkg::CFG_DATA_W-1:0]);
    cfg_write(acs_pkg::REG_START_Z, oz[acs_pkg::CFG_DATA_W-1:0]);
    cfg_write(acs_pkg::REG_THRESH, thr[acs_pkg::CFG_DATA_W-1:0]);
    cfg_write(acs_pkg::REG_ONE_G, one_g[acs_pkg::CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // hold off until every queued word has its status word back
  task automatic wait_drained();
    while (words_accepted != words_queued || expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // a held-still run: near-constant samples, buttons mostly held
  task automatic add_session();
    int len;
    int jit;
    int bx, by, bz;
    int x, y, z;
    len = int'($urandom_range(330, 60));
    jit = ($urandom_range(2) == 0) ? 1 : 0;
    case ($urandom_range(2))
      0: begin
        // resting flat, close to one g on z
        bx = $urandom_range(1) ? 0 : int'($urandom_range(2)) - 1;
        by = $urandom_range(1) ? 0 : int'($urandom_range(2)) - 1;
        bz = fit_sample(model_one_g + ($urandom_range(1) ? 0 : int'($urandom_range(2)) - 1));
      end
      1: begin
        bx = rnd_sample();
        by = rnd_sample();
        bz = rnd_sample();
      end
      default: begin
        bx = int'($urandom_range(80)) - 40;
        by = int'($urandom_range(80)) - 40;
        bz = fit_sample(model_one_g + int'($urandom_range(80)) - 40);
      end
    endcase
    for (int k = 0; k < len; k++) begin
      x = fit_sample(bx + (jit ? int'($urandom_range(2)) - 1 : 0));
      y = fit_sample(by + (jit ? int'($urandom_range(2)) - 1 : 0));
      z = fit_sample(bz + (jit ? int'($urandom_range(2)) - 1 : 0));
      // rare knock
      if ($urandom_range(199) == 0) x = rnd_sample();
      push_word(x, y, z, $urandom_range(15) != 0);
    end
  endtask

  task automatic add_noise();
    int len;
    len = int'($urandom_range(40, 5));
    for (int k = 0; k < len; k++) begin
      push_word(rnd_sample(), rnd_sample(), rnd_sample(), $urandom_range(1) == 1);
    end
  endtask

  // stimulus
  initial begin
    int  phase_start;
    bit  paused;
    in_bus.valid        = 1'b0;
    in_bus.sample_x     = '0;
    in_bus.sample_y     = '0;
    in_bus.sample_z     = '0;
    in_bus.buttons_held = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    for (int i = 0; i < 3; i++) begin
      model_sum[i]    = 0;
      model_mean[i]   = 0;
      model_offset[i] = 0;
    end
    model_phase = '0;
    model_thr   = int'(acs_pkg::THR_RESET);
    model_one_g = int'(acs_pkg::ONEG_RESET);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unused register indexes, extreme settings, extreme samples
    for (int k = int'(acs_pkg::REG_ONE_G) + 1; k < (1 << acs_pkg::CFG_IDX_W); k++) begin
      cfg_write(acs_pkg::CFG_IDX_W'(k), acs_pkg::CFG_DATA_W'($urandom));
    end
    load_settings(int'(acs_pkg::OFF_HI), int'(acs_pkg::OFF_LO), 0,
                  (1 << acs_pkg::THR_W) - 1, (1 << acs_pkg::ONEG_W) - 1);
    for (int k = 0; k < 8; k++) push_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    for (int k = 0; k < 8; k++) push_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    for (int k = 0; k < 8; k++) begin
      push_word(k[0] ? SAMPLE_MAX : SAMPLE_MIN, k[1] ? SAMPLE_MIN : 0,
                k[2] ? 0 : SAMPLE_MAX, k[0]);
    end
    wait_drained();

    // random phases under several settings and idle patterns
    for (int p = 0; p < 6; p++) begin
      gap_mode = (p < 2) ? IDLE_RX_HEAVY : (p < 4) ? IDLE_TX_HEAVY : IDLE_NONE;
      case (p)
        0: load_settings(rnd_offset(), rnd_offset(), rnd_offset(),
                         int'(acs_pkg::THR_RESET), int'(acs_pkg::ONEG_RESET));
        1: load_settings(int'(acs_pkg::OFF_HI), int'(acs_pkg::OFF_LO),
                         int'(acs_pkg::OFF_HI), 0, 0);
        2: load_settings(int'(acs_pkg::OFF_LO), int'(acs_pkg::OFF_HI), int'(acs_pkg::OFF_LO),
                         (1 << acs_pkg::THR_W) - 1, (1 << acs_pkg::ONEG_W) - 1);
        default: load_settings(int'($urandom), int'($urandom), int'($urandom),
                               int'($urandom), int'($urandom));
      endcase
      phase_start = words_queued;
      paused      = 1'b0;
      while (words_queued - phase_start < WORDS_PER_PHASE) begin
        if ($urandom_range(3) != 0) add_session();
        else add_noise();
        // let the block run dry once in the middle of the phase
        if (!paused && words_queued - phase_start >= WORDS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    // catch late or extra status words
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
